// ----- hdl/mrcc_pkg.sv -----
// Shared types, constants and helper functions for the MPU region checker.
// Used by mrcc_cell and mpu_region_config_checker; depends on nothing.
`default_nettype none
package mrcc_pkg;

    localparam int MAX_REGIONS_DEF = 8;
    localparam int SUBREGION_COUNT = 8;
    localparam logic [31:0] ATTR_LOW_MASK  = 32'h0000_FFFF;
    localparam logic [31:0] RBAR_ADDR_MASK = 32'hFFFF_FFE0;
    localparam logic [31:0] MIN_REGION     = 32'd32;
    localparam logic [31:0] MIN_SUB_REGION = 32'd256;
    localparam logic [3:0]  REGION_COUNT_RST    = 4'd8;
    localparam logic [2:0]  PARTITION_COUNT_RST = 3'd3;

    typedef enum logic [1:0] {
        OP_CONFIG     = 2'd0,
        OP_CONFIG_SRD = 2'd1,
        OP_ENABLE     = 2'd2,
        OP_DISABLE    = 2'd3
    } op_t;

    typedef enum logic {
        CFG_REGION_COUNT    = 1'b0,
        CFG_PARTITION_COUNT = 1'b1
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_CHAIN = 2'd2,
        ST_DONE  = 2'd3
    } state_t;

    typedef struct packed {
        logic [31:0] base;
        logic [31:0] size;
        logic [31:0] attr;
        logic [7:0]  srd;
        logic        en;
    } entry_t;

    typedef struct packed {
        logic [31:0] base;
        logic [32:0] end_addr;
        logic        whole;
        logic [3:0]  nid;
        logic [2:0]  part_cnt;
        logic [4:0]  eff_cnt;
    } req_t;

    typedef struct packed {
        logic        start;
        logic        step;
        logic [2:0]  sub;
        logic        chain;
        logic        wr;
        logic        wr_cfg;
        logic        wr_en_val;
        entry_t      wr_entry;
    } ctrl_t;

    function automatic logic [4:0] size_log2(input logic [31:0] s);
        logic [4:0] lg;
        lg = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (s[i])
            begin
                lg = lg | 5'(i);
            end
        end
        return lg;
    endfunction

    function automatic logic valid_size(input logic [31:0] s);
        return (s >= MIN_REGION) && ((s & (s - 32'd1)) == 32'd0);
    endfunction

    function automatic logic [31:0] size_enc(input logic [31:0] s);
        logic [4:0] lgm1;
        lgm1 = size_log2(s) - 5'd1;
        return valid_size(s) ? {26'd0, lgm1, 1'b0} : 32'd0;
    endfunction

endpackage
`default_nettype wire

// ----- hdl/mrcc_cell.sv -----
// One region cell of the checker chain: holds one table entry and tests it
// against the pending request. Depends on mrcc_pkg.
`default_nettype none
module mrcc_cell #(
    parameter int ID = 0
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  mrcc_pkg::ctrl_t     ctrl,
    input  mrcc_pkg::req_t      req,
    input  wire                 carry_in,
    output logic                carry_out,
    output mrcc_pkg::entry_t    entry
);

    mrcc_pkg::entry_t entry_reg;
    mrcc_pkg::entry_t entry_next;
    logic [32:0] lo_reg;
    logic [32:0] lo_next;
    logic        hit_reg;
    logic        hit_next;
    logic        carry_reg;
    logic        carry_next;

    logic [32:0] b1;
    logic [32:0] b2;
    logic [32:0] e2;
    logic [32:0] u2;
    logic        ext;
    logic        whole;
    logic        sub_hit;
    logic        allowed;
    logic        conflict;
    logic        is_me;
    logic [4:0]  id5;

    always_comb
    begin
        id5     = 5'(ID);
        is_me   = ({1'b0, req.nid} == id5);
        b1      = {1'b0, req.base};
        b2      = {1'b0, entry_reg.base};
        e2      = b2 + {1'b0, entry_reg.size};
        u2      = {4'd0, entry_reg.size[31:3]};
        ext     = (req.end_addr > 33'h1_0000_0000) || ((req.end_addr > b2) && (e2 > b1));
        whole   = req.whole || (entry_reg.size < mrcc_pkg::MIN_SUB_REGION);
        sub_hit = !entry_reg.srd[ctrl.sub] && (lo_reg < req.end_addr) && (b1 < lo_reg + u2);
        allowed = (id5 < req.eff_cnt) && (id5 != 5'd0) && (req.nid != 4'd0)
                  && ({1'b0, req.nid} > {2'd0, req.part_cnt})
                  && (id5 <= {2'd0, req.part_cnt})
                  && ({1'b0, req.nid} == id5 + {2'd0, req.part_cnt});
        conflict = !is_me && (entry_reg.size != 32'd0) && ext && (whole || hit_reg) && !allowed;

        lo_next    = lo_reg;
        hit_next   = hit_reg;
        carry_next = carry_reg;
        entry_next = entry_reg;
        if (ctrl.start)
        begin
            lo_next    = b2;
            hit_next   = 1'b0;
            carry_next = 1'b0;
        end
        else if (ctrl.step)
        begin
            lo_next  = lo_reg + u2;
            hit_next = hit_reg | sub_hit;
        end
        else if (ctrl.chain)
        begin
            carry_next = carry_in | conflict;
        end
        if (ctrl.wr && is_me)
        begin
            if (ctrl.wr_cfg)
            begin
                entry_next = ctrl.wr_entry;
            end
            else
            begin
                entry_next.en = ctrl.wr_en_val;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
            carry_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            entry_reg <= entry_next;
            carry_reg <= carry_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
    end

    assign carry_out = carry_reg;
    assign entry     = entry_reg;

endmodule
`default_nettype wire

// ----- hdl/mpu_region_config_checker.sv -----
// Top level of the MPU region checker: request control, configuration and
// the chain of region cells. Depends on mrcc_pkg and mrcc_cell.
//
// Channel   Dir  Width  Contents
// s_axis    in   136    operation, region_index, base, size, used size, attributes
// m_axis    out  80     status, RASR word, RBAR word, subregion mask
// cfg       in   4      region count (index 0), partition count (index 1)
//
// A request passes from acceptance to its result through a load step, eight
// subregion steps in every cell, a ripple of the conflict flag down the cell
// chain, and a final step that updates the table.
// One request is in flight at a time; a held result stalls only the next one.
// Reset clears the region table at once and restores the default counts.
`default_nettype none
module mpu_region_config_checker #(
    parameter int MAX_REGIONS = mrcc_pkg::MAX_REGIONS_DEF
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // operation[1:0], region_index[5:2], base_address[37:6], region_size[69:38],
    // used_size[101:70], access_attributes[133:102], zero pad
    input  wire  [135:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // status[0], rasr_word[32:1], rbar_word[64:33], subregion_mask[72:65], zero pad
    output logic [79:0]  m_axis_tdata,
    input  wire          cfg_we,
    input  wire          cfg_index,
    input  wire  [3:0]   cfg_data
);

    localparam int CNTW = $clog2(MAX_REGIONS + 8);

    mrcc_pkg::state_t state_reg;
    mrcc_pkg::state_t state_next;
    logic [CNTW-1:0]  cnt_reg;
    logic [CNTW-1:0]  cnt_next;
    logic [3:0]       rcount_reg;
    logic [2:0]       pcount_reg;
    logic [1:0]       op_reg;
    logic [3:0]       rid_reg;
    logic [31:0]      base_reg;
    logic [31:0]      size_reg;
    logic [31:0]      used_reg;
    logic [31:0]      attr_reg;
    logic             oval_reg;
    logic             oval_next;
    logic [79:0]      odata_reg;
    logic [79:0]      odata_next;

    mrcc_pkg::ctrl_t  ctrl;
    mrcc_pkg::req_t   req;
    mrcc_pkg::entry_t entries [MAX_REGIONS];
    mrcc_pkg::entry_t cur;
    mrcc_pkg::entry_t new_entry;
    logic [MAX_REGIONS:0] carry;

    logic [4:0]  eff;
    logic        accept;
    logic        pre_ok;
    logic        is_cfg;
    logic        ok;
    logic [4:0]  lg;
    logic [4:0]  shamt;
    logic [31:0] used_sh;
    logic [3:0]  first_off;
    logic [8:0]  srd_wide;
    logic [7:0]  srd_new;
    logic        aligned;
    logic [31:0] rasr;
    logic [31:0] rbar;
    logic [7:0]  smask;
    logic [CNTW-1:0] last_chain;

    assign eff    = ({1'b0, rcount_reg} > 5'(MAX_REGIONS)) ? 5'(MAX_REGIONS)
                                                           : {1'b0, rcount_reg};
    assign accept = s_axis_tvalid && s_axis_tready;
    assign is_cfg = (op_reg == mrcc_pkg::OP_CONFIG) || (op_reg == mrcc_pkg::OP_CONFIG_SRD);
    assign aligned = (base_reg & (size_reg - 32'd1)) == 32'd0;
    assign lg = mrcc_pkg::size_log2(size_reg);
    assign last_chain = CNTW'(MAX_REGIONS - 1);

    always_comb
    begin
        req.base     = base_reg;
        req.end_addr = {1'b0, base_reg} + {1'b0, size_reg};
        req.whole    = (size_reg < mrcc_pkg::MIN_SUB_REGION) || !aligned;
        req.nid      = rid_reg;
        req.part_cnt = pcount_reg;
        req.eff_cnt  = eff;
    end

    assign carry[0] = 1'b0;
    for (genvar i = 0; i < MAX_REGIONS; i++)
    begin : g_cell
        mrcc_cell #(
            .ID (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .req       (req),
            .carry_in  (carry[i]),
            .carry_out (carry[i+1]),
            .entry     (entries[i])
        );
    end

    always_comb
    begin
        cur = '0;
        for (int i = 0; i < MAX_REGIONS; i++)
        begin
            if ({1'b0, rid_reg} == 5'(i))
            begin
                cur = entries[i];
            end
        end
    end

    always_comb
    begin
        shamt    = lg - 5'd3;
        used_sh  = (used_reg - 32'd1) >> shamt;
        first_off = {1'b0, used_sh[2:0]} + 4'd1;
        srd_wide = 9'h1FF << first_off;
        srd_new  = ((op_reg == mrcc_pkg::OP_CONFIG_SRD)
                    && (size_reg >= mrcc_pkg::MIN_SUB_REGION)) ? srd_wide[7:0] : 8'h00;

        pre_ok = ({1'b0, rid_reg} < eff)
                 && (!is_cfg
                     || (mrcc_pkg::valid_size(size_reg) && aligned
                         && ((attr_reg & mrcc_pkg::ATTR_LOW_MASK) == 32'd0)
                         && ((op_reg == mrcc_pkg::OP_CONFIG)
                             || ((used_reg != 32'd0) && (used_reg <= size_reg)))));
        ok = pre_ok && (!is_cfg || !carry[MAX_REGIONS]);

        new_entry.base = base_reg;
        new_entry.size = size_reg;
        new_entry.attr = attr_reg;
        new_entry.srd  = srd_new;
        new_entry.en   = 1'b1;

        if (is_cfg)
        begin
            rasr  = mrcc_pkg::size_enc(size_reg) | attr_reg | {16'd0, srd_new, 8'd0} | 32'd1;
            rbar  = base_reg & mrcc_pkg::RBAR_ADDR_MASK;
            smask = srd_new;
        end
        else
        begin
            rasr  = mrcc_pkg::size_enc(cur.size) | cur.attr | {16'd0, cur.srd, 8'd0}
                    | {31'd0, op_reg == mrcc_pkg::OP_ENABLE};
            rbar  = cur.base & mrcc_pkg::RBAR_ADDR_MASK;
            smask = cur.srd;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        oval_next  = oval_reg && !m_axis_tready;
        odata_next = odata_reg;
        s_axis_tready = 1'b0;
        ctrl = '0;
        ctrl.sub       = cnt_reg[2:0];
        ctrl.wr_cfg    = is_cfg;
        ctrl.wr_en_val = (op_reg == mrcc_pkg::OP_ENABLE);
        ctrl.wr_entry  = new_entry;
        case (state_reg)
            mrcc_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    state_next = mrcc_pkg::ST_SCAN;
                    cnt_next   = '0;
                end
            end
            mrcc_pkg::ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    ctrl.start = 1'b1;
                    cnt_next   = cnt_reg + CNTW'(1);
                end
                else
                begin
                    ctrl.step = 1'b1;
                    ctrl.sub  = 3'(cnt_reg - CNTW'(1));
                    if (cnt_reg == CNTW'(8))
                    begin
                        state_next = mrcc_pkg::ST_CHAIN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CNTW'(1);
                    end
                end
            end
            mrcc_pkg::ST_CHAIN:
            begin
                ctrl.chain = 1'b1;
                if (cnt_reg == last_chain)
                begin
                    state_next = mrcc_pkg::ST_DONE;
                end
                cnt_next = cnt_reg + CNTW'(1);
            end
            mrcc_pkg::ST_DONE:
            begin
                if (!oval_reg || m_axis_tready)
                begin
                    ctrl.wr    = ok;
                    oval_next  = 1'b1;
                    odata_next = ok ? {7'd0, smask, rbar, rasr, 1'b0} : {79'd0, 1'b1};
                    state_next = mrcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrcc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mrcc_pkg::ST_IDLE;
            cnt_reg    <= '0;
            oval_reg   <= 1'b0;
            rcount_reg <= mrcc_pkg::REGION_COUNT_RST;
            pcount_reg <= mrcc_pkg::PARTITION_COUNT_RST;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            oval_reg  <= oval_next;
            if (cfg_we)
            begin
                if (cfg_index == mrcc_pkg::CFG_REGION_COUNT)
                begin
                    rcount_reg <= cfg_data;
                end
                else
                begin
                    pcount_reg <= cfg_data[2:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        odata_reg <= odata_next;
        if (accept)
        begin
            op_reg   <= s_axis_tdata[1:0];
            rid_reg  <= s_axis_tdata[5:2];
            base_reg <= s_axis_tdata[37:6];
            size_reg <= s_axis_tdata[69:38];
            used_reg <= s_axis_tdata[101:70];
            attr_reg <= s_axis_tdata[133:102];
        end
    end

    assign m_axis_tvalid = oval_reg;
    assign m_axis_tdata  = odata_reg;

    a_done_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mrcc_pkg::ST_DONE && state_next == mrcc_pkg::ST_IDLE) |=> m_axis_tvalid)
        else $error("finished request produced no result");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tdata[72:1] == 72'd0))
        else $error("rejected request carries non-zero words");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready)
        else $error("second request taken while one is in flight");

endmodule
`default_nettype wire

// ----- verif/tb_mpu_region_config_checker.sv -----
// Self-checking testbench for mpu_region_config_checker: directed and random region
// requests, predicted in the testbench and compared against every result.
// Depends on mrcc_pkg and the mpu_region_config_checker RTL.
`default_nettype none
module tb_mpu_region_config_checker;

    typedef struct packed {
        logic        status;
        logic [31:0] rasr;
        logic [31:0] rbar;
        logic [7:0]  mask;
    } region_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    wire          s_axis_tready;
    logic [135:0] s_axis_tdata = '0;
    wire          m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    wire  [79:0]  m_axis_tdata;
    logic         cfg_we = 1'b0;
    logic         cfg_index = 1'b0;
    logic [3:0]   cfg_data = '0;

    mpu_region_config_checker dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    logic [31:0] tbl_base [8];
    logic [31:0] tbl_size [8];
    logic [7:0]  tbl_srd  [8];
    logic        tbl_en   [8];
    logic [31:0] tbl_attr [8];
    logic [3:0]  num_regions = mrcc_pkg::REGION_COUNT_RST;
    logic [2:0]  num_partitions = mrcc_pkg::PARTITION_COUNT_RST;

    region_result_t pending_results[$];
    int errors = 0;
    int rx_hold_cycles = 0;
    int idle_cycles = 0;

    function automatic logic [31:0] usable_regions();
        return (num_regions > 8) ? 32'd8 : 32'(num_regions);
    endfunction

    function automatic bit pow2_ok(logic [31:0] s);
        return s >= 32 && (s & (s - 1)) == 0;
    endfunction

    function automatic bit is_aligned(logic [31:0] b, logic [31:0] s);
        return s != 0 && (b & (s - 1)) == 0;
    endfunction

    function automatic logic [31:0] encoded_size(logic [31:0] s);
        logic [31:0] lg;
        lg = 0;
        if (!pow2_ok(s))
        begin
            return 0;
        end
        for (int i = 0; i < 32; i++)
        begin
            if (s[i])
            begin
                lg = i;
            end
        end
        return ((lg - 1) << 1) & 32'h3E;
    endfunction

    function automatic bit spans_meet(logic [31:0] b1, logic [31:0] s1,
                                      logic [31:0] b2, logic [31:0] s2);
        logic [63:0] e1, e2;
        if (s1 == 0 || s2 == 0)
        begin
            return 0;
        end
        e1 = 64'(b1) + 64'(s1);
        e2 = 64'(b2) + 64'(s2);
        if (e1 > 64'h1_0000_0000 || e2 > 64'h1_0000_0000)
        begin
            return 1;
        end
        return !(e1 <= 64'(b2) || e2 <= 64'(b1));
    endfunction

    function automatic bit subregions_meet(logic [31:0] b1, logic [31:0] s1, logic [7:0] m1,
                                           logic [31:0] b2, logic [31:0] s2, logic [7:0] m2);
        logic [63:0] u1, u2, lo1, hi1, lo2, hi2;
        if (!spans_meet(b1, s1, b2, s2))
        begin
            return 0;
        end
        if (s1 < 256 || s2 < 256 || !is_aligned(b1, s1) || !is_aligned(b2, s2))
        begin
            return 1;
        end
        u1 = 64'(s1) / 8;
        u2 = 64'(s2) / 8;
        for (int i = 0; i < 8; i++)
        begin
            if (m1[i])
            begin
                continue;
            end
            lo1 = 64'(b1) + i * u1;
            hi1 = lo1 + u1;
            for (int j = 0; j < 8; j++)
            begin
                if (m2[j])
                begin
                    continue;
                end
                lo2 = 64'(b2) + j * u2;
                hi2 = lo2 + u2;
                if (lo1 < hi2 && lo2 < hi1)
                begin
                    return 1;
                end
            end
        end
        return 0;
    endfunction

    function automatic logic [31:0] owner_partition(logic [31:0] id);
        return (id <= 32'(num_partitions)) ? id - 1 : id - 1 - 32'(num_partitions);
    endfunction

    function automatic bit code_over_data(logic [31:0] nid, logic [31:0] eid);
        logic [31:0] n;
        n = usable_regions();
        if (nid >= n || eid >= n || nid == 0 || eid == 0)
        begin
            return 0;
        end
        if (owner_partition(nid) != owner_partition(eid))
        begin
            return 0;
        end
        return nid > 32'(num_partitions) && eid <= 32'(num_partitions);
    endfunction

    function automatic bit no_conflict(logic [31:0] nid, logic [31:0] b, logic [31:0] s);
        for (int i = 0; i < 8; i++)
        begin
            if (i == nid || tbl_size[i] == 0)
            begin
                continue;
            end
            if (subregions_meet(b, s, 8'h00, tbl_base[i], tbl_size[i], tbl_srd[i])
                && !code_over_data(nid, i))
            begin
                return 0;
            end
        end
        return 1;
    endfunction

    task automatic predict_region_request(mrcc_pkg::op_t op, logic [3:0] idx, logic [31:0] b,
                                          logic [31:0] s, logic [31:0] used,
                                          logic [31:0] attr);
        region_result_t res;
        logic [7:0] srd;
        logic [63:0] sub, cnt;
        bit ok;
        res = '{status: 1'b1, rasr: '0, rbar: '0, mask: '0};
        srd = 8'h00;
        ok = 32'(idx) < usable_regions();
        if (ok && (op == mrcc_pkg::OP_CONFIG || op == mrcc_pkg::OP_CONFIG_SRD))
        begin
            ok = pow2_ok(s) && (attr & mrcc_pkg::ATTR_LOW_MASK) == 0;
            if (op == mrcc_pkg::OP_CONFIG)
            begin
                ok = ok && is_aligned(b, s) && no_conflict(idx, b, s);
            end
            else
            begin
                ok = ok && used != 0 && used <= s && no_conflict(idx, b, s)
                     && is_aligned(b, s);
                if (ok && s >= 256)
                begin
                    sub = 64'(s) / 8;
                    cnt = (64'(used) + sub - 1) / sub;
                    for (int i = 0; i < 8; i++)
                    begin
                        if (i >= cnt)
                        begin
                            srd[i] = 1'b1;
                        end
                    end
                end
            end
            if (ok)
            begin
                tbl_base[idx] = b;
                tbl_size[idx] = s;
                tbl_attr[idx] = attr;
                tbl_srd[idx] = srd;
                tbl_en[idx] = 1'b1;
            end
        end
        else if (ok)
        begin
            tbl_en[idx] = (op == mrcc_pkg::OP_ENABLE);
        end
        if (ok)
        begin
            res.status = 1'b0;
            res.rasr = encoded_size(tbl_size[idx]) | tbl_attr[idx]
                       | (32'(tbl_srd[idx]) << 8) | 32'(tbl_en[idx]);
            res.rbar = tbl_base[idx] & mrcc_pkg::RBAR_ADDR_MASK;
            res.mask = tbl_srd[idx];
        end
        pending_results.push_back(res);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(mrcc_pkg::op_t op, logic [3:0] idx, logic [31:0] b,
                                logic [31:0] s, logic [31:0] used, logic [31:0] attr,
                                int gap);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata <= {2'b00, attr, used, s, b, idx, op};
        s_axis_tvalid <= 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (!s_axis_tready);
        @(posedge clk);
        predict_region_request(op, idx, b, s, used, attr);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (mrcc_pkg::MAX_REGIONS_DEF + 12) @(posedge clk);
    endtask

    task automatic write_cfg(mrcc_pkg::cfg_idx_t idx, logic [3:0] value);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == mrcc_pkg::CFG_REGION_COUNT)
        begin
            num_regions = value;
        end
        else
        begin
            num_partitions = value[2:0];
        end
    endtask

    task automatic test_directed();
        write_cfg(mrcc_pkg::CFG_REGION_COUNT, 4'd8);
        write_cfg(mrcc_pkg::CFG_PARTITION_COUNT, 4'd3);
        send_request(mrcc_pkg::OP_ENABLE, 4'd6, 0, 0, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd15, 0, 32, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd8, 0, 32, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd1, 0, 16, 0, 0, 1);
        send_request(mrcc_pkg::OP_CONFIG, 4'd1, 0, 32'h60, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd1, 32'h20, 32'h40, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd1, 0, 32'h40, 0, 32'h0001_0000 | 32'h1, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd1, 32'h2000_0000, 32'h1000, 0, 32'hFFFF_0000, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd4, 32'h2000_0800, 32'h800, 0, 32'h0300_0000, 2);
        send_request(mrcc_pkg::OP_CONFIG, 4'd5, 32'h2000_0000, 32'h100, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG_SRD, 4'd2, 32'h3000_0000, 32'h1000, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG_SRD, 4'd2, 32'h3000_0000, 32'h1000, 32'h1001, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG_SRD, 4'd2, 32'h3000_0000, 32'h1000, 32'h400, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd3, 32'h3000_0800, 32'h800, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG_SRD, 4'd7, 32'h4000_0000, 32'h80, 32'h11, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG_SRD, 4'd7, 32'h4000_0010, 32'h100, 32'h1, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd6, 32'hFFFF_FFE0, 32'h20, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF, 0);
        send_request(mrcc_pkg::OP_DISABLE, 4'd1, 0, 0, 0, 0, 0);
        send_request(mrcc_pkg::OP_ENABLE, 4'd1, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_request(mrcc_pkg::OP_DISABLE, 4'd7, 0, 0, 0, 0, 0);
        write_cfg(mrcc_pkg::CFG_REGION_COUNT, 4'd0);
        send_request(mrcc_pkg::OP_ENABLE, 4'd0, 0, 0, 0, 0, 0);
        send_request(mrcc_pkg::OP_CONFIG, 4'd0, 0, 32, 0, 0, 0);
    endtask

    task automatic send_random(int count, logic [31:0] window);
        logic [31:0] s, b, used, attr;
        logic [3:0] idx;
        mrcc_pkg::op_t op;
        int r, lg;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            idx = ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 7));
            op = mrcc_pkg::op_t'((r < 40) ? mrcc_pkg::OP_CONFIG
                                 : (r < 75) ? mrcc_pkg::OP_CONFIG_SRD
                                 : (r < 88) ? mrcc_pkg::OP_ENABLE : mrcc_pkg::OP_DISABLE);
            lg = ($urandom_range(0, 29) == 0) ? $urandom_range(5, 31) : $urandom_range(5, 13);
            s = 32'h1 << lg;
            b = window + ($urandom_range(0, 63) << lg);
            used = $urandom_range(1, s);
            attr = $urandom & 32'hFFFF_0000;
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: b = $urandom;
                    1: s = $urandom;
                    2: used = ($urandom_range(0, 1) == 0) ? 32'd0 : $urandom;
                    default: attr = $urandom;
                endcase
            end
            send_request(op, idx, b, s, used, attr, pick_gap());
        end
    endtask

    task automatic test_random_phases();
        write_cfg(mrcc_pkg::CFG_REGION_COUNT, 4'd8);
        write_cfg(mrcc_pkg::CFG_PARTITION_COUNT, 4'd3);
        send_random(500, 32'h2000_0000);
        write_cfg(mrcc_pkg::CFG_PARTITION_COUNT, 4'd1);
        send_random(350, 32'h0000_0000);
        write_cfg(mrcc_pkg::CFG_REGION_COUNT, 4'd15);
        write_cfg(mrcc_pkg::CFG_PARTITION_COUNT, 4'd7);
        send_random(350, 32'hFFF0_0000);
        write_cfg(mrcc_pkg::CFG_REGION_COUNT, 4'd5);
        write_cfg(mrcc_pkg::CFG_PARTITION_COUNT, 4'd2);
        send_random(350, 32'h6000_0000);
        write_cfg(mrcc_pkg::CFG_REGION_COUNT, 4'd0);
        send_random(60, 32'h1000_0000);
        write_cfg(mrcc_pkg::CFG_REGION_COUNT, 4'd8);
        write_cfg(mrcc_pkg::CFG_PARTITION_COUNT, 4'd4);
        send_random(350, 32'h9000_0000);
    endtask

    task automatic test_backpressure();
        wait_idle();
        rx_hold_cycles = 400;
        for (int n = 0; n < 20; n++)
        begin
            send_request(mrcc_pkg::OP_ENABLE, 4'($urandom_range(0, 7)), 0, 0, 0, 0, 0);
        end
        wait_idle();
    endtask

    always @(posedge clk)
    begin
        if (rx_hold_cycles > 0)
        begin
            m_axis_tready <= 1'b0;
            rx_hold_cycles <= rx_hold_cycles - 1;
        end
        else
        begin
            m_axis_tready <= (pick_gap() == 0) || ($urandom_range(0, 3) == 0);
        end
    end

    always @(negedge clk)
    begin
        region_result_t got, want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            got = '{status: m_axis_tdata[0], rasr: m_axis_tdata[32:1],
                    rbar: m_axis_tdata[64:33], mask: m_axis_tdata[72:65]};
            if (pending_results.size() == 0)
            begin
                $error("unexpected result %h", got);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %h, got %h", want.status, got.status);
                    errors++;
                end
                if (got.rasr !== want.rasr)
                begin
                    $error("rasr_word: expected %h, got %h", want.rasr, got.rasr);
                    errors++;
                end
                if (got.rbar !== want.rbar)
                begin
                    $error("rbar_word: expected %h, got %h", want.rbar, got.rbar);
                    errors++;
                end
                if (got.mask !== want.mask)
                begin
                    $error("subregion_mask: expected %h, got %h", want.mask, got.mask);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= 4000)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        for (int i = 0; i < 8; i++)
        begin
            tbl_base[i] = '0;
            tbl_size[i] = '0;
            tbl_srd[i] = '0;
            tbl_en[i] = 1'b0;
            tbl_attr[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_phases();
        wait_idle();
        if (pending_results.size() != 0)
        begin
            $error("%0d results never arrived", pending_results.size());
            errors++;
        end
        if (errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
hdl/mrcc_pkg.sv
hdl/mrcc_cell.sv
hdl/mpu_region_config_checker.sv
verif/tb_mpu_region_config_checker.sv
